// ===== hw/rtl/dft15_pkg.sv =====
//------------------------------------------------------------------------------
// dft15_pkg
// Shared widths, constants, types and Q1.16 twiddle tables of the 15-point DFT.
//------------------------------------------------------------------------------
`default_nettype none

package dft15_pkg;

	localparam int FRAME_LEN = 15;
	localparam int IDX_W     = 4;
	localparam int SAMPLE_W  = 16;
	localparam int BIN_W     = 20;
	localparam int TW_W      = 18;
	localparam int PROD_W    = SAMPLE_W + TW_W;
	localparam int ACC_W     = 37;
	localparam int FRAC_W    = 16;
	localparam int RAM_AW    = IDX_W + 1;
	localparam int RAM_DEPTH = 1 << RAM_AW;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W:0]   MOD_LEN  = (IDX_W + 1)'(FRAME_LEN);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);

	// frame queue status, front to back
	typedef struct packed {
		logic avail;
		logic bank;
	} frame_info_t;

	function automatic logic signed [TW_W-1:0] cos_q16(input logic [IDX_W-1:0] m);
		logic signed [TW_W-1:0] c;
		unique case (m)
			4'd0:    c = 18'sd65536;
			4'd1:    c = 18'sd59870;
			4'd2:    c = 18'sd43852;
			4'd3:    c = 18'sd20252;
			4'd4:    c = -18'sd6850;
			4'd5:    c = -18'sd32768;
			4'd6:    c = -18'sd53020;
			4'd7:    c = -18'sd64104;
			4'd8:    c = -18'sd64104;
			4'd9:    c = -18'sd53020;
			4'd10:   c = -18'sd32768;
			4'd11:   c = -18'sd6850;
			4'd12:   c = 18'sd20252;
			4'd13:   c = 18'sd43852;
			4'd14:   c = 18'sd59870;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [TW_W-1:0] sin_q16(input logic [IDX_W-1:0] m);
		logic signed [TW_W-1:0] s;
		unique case (m)
			4'd0:    s = 18'sd0;
			4'd1:    s = 18'sd26656;
			4'd2:    s = 18'sd48703;
			4'd3:    s = 18'sd62328;
			4'd4:    s = 18'sd65177;
			4'd5:    s = 18'sd56756;
			4'd6:    s = 18'sd38521;
			4'd7:    s = 18'sd13626;
			4'd8:    s = -18'sd13626;
			4'd9:    s = -18'sd38521;
			4'd10:   s = -18'sd56756;
			4'd11:   s = -18'sd65177;
			4'd12:   s = -18'sd62328;
			4'd13:   s = -18'sd48703;
			4'd14:   s = -18'sd26656;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dft15_ram.sv =====
//------------------------------------------------------------------------------
// dft15_ram
// Generic simple dual-port RAM, one write port, one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module dft15_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dft15_front.sv =====
//------------------------------------------------------------------------------
// dft15_front
// Sample intake: fill count, bank select and the two-frame queue of full banks.
//------------------------------------------------------------------------------
`default_nettype none

module dft15_front
	import dft15_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                release_frame,
	output frame_info_t              frame_info,
	output logic                     wr_en,
	output logic [RAM_AW-1:0]        wr_addr,
	output logic [SAMPLE_W-1:0]      wr_data
);

	logic [IDX_W-1:0] fill_q;
	logic             wr_bank_q;
	logic             rd_bank_q;
	logic [1:0]       frames_q;
	logic             push;

	// both banks full means no room for another frame
	assign in_ready = (frames_q != 2'd2);
	assign wr_en    = in_valid && in_ready;
	assign wr_addr  = {wr_bank_q, fill_q};
	assign wr_data  = sample;
	assign push     = wr_en && (fill_q == LAST_IDX);

	assign frame_info.avail = (frames_q != 2'd0);
	assign frame_info.bank  = rd_bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			frames_q  <= '0;
		end else begin
			if (wr_en) begin
				if (fill_q == LAST_IDX) begin
					fill_q    <= '0;
					wr_bank_q <= ~wr_bank_q;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (release_frame) begin
				rd_bank_q <= ~rd_bank_q;
			end
			if (push && !release_frame) begin
				frames_q <= frames_q + 1'b1;
			end else if (!push && release_frame) begin
				frames_q <= frames_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dft15_back.sv =====
//------------------------------------------------------------------------------
// dft15_back
// Bin engine: sequencer over (k, n), shared complex MAC, rounding output register.
//------------------------------------------------------------------------------
`default_nettype none

module dft15_back
	import dft15_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  frame_info_t              frame_info,
	output logic                     release_frame,
	output logic                     rd_en,
	output logic [RAM_AW-1:0]        rd_addr,
	input  wire logic [SAMPLE_W-1:0] rd_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [BIN_W-1:0]         bin_real,
	output logic [BIN_W-1:0]         bin_imag,
	output logic [IDX_W-1:0]         bin_index,
	output logic                     last_bin
);

	logic adv;
	logic issue;

	logic [IDX_W-1:0] n_q, k_q, m_q;
	logic [IDX_W:0]   m_sum;
	logic [IDX_W-1:0] m_nx;

	logic             v_s1, first_s1, lastn_s1;
	logic [IDX_W-1:0] m_s1, k_s1;

	logic                     v_s2, first_s2, lastn_s2;
	logic [IDX_W-1:0]         k_s2;
	logic signed [PROD_W-1:0] prod_re_s2, prod_im_s2;

	logic                    done_s3;
	logic [IDX_W-1:0]        k_s3;
	logic signed [ACC_W-1:0] acc_re_s3, acc_im_s3;
	logic signed [ACC_W-1:0] prod_re_ext, prod_im_ext;
	logic signed [ACC_W-1:0] rnd_re, rnd_im;

	logic out_valid_q;

	// whole pipeline freezes while a result waits in the output register
	assign adv   = !out_valid_q || out_ready;
	assign issue = adv && frame_info.avail;

	assign rd_en   = adv;
	assign rd_addr = {frame_info.bank, n_q};

	// frame bank is free once its last sample has been read
	assign release_frame = issue && (n_q == LAST_IDX) && (k_q == LAST_IDX);

	// twiddle index m = n*k mod 15, stepped by k
	assign m_sum = {1'b0, m_q} + {1'b0, k_q};
	assign m_nx  = (m_sum >= MOD_LEN) ? IDX_W'(m_sum - MOD_LEN) : m_sum[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
			m_q <= '0;
		end else if (issue) begin
			if (n_q == LAST_IDX) begin
				n_q <= '0;
				m_q <= '0;
				k_q <= (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
			end else begin
				n_q <= n_q + 1'b1;
				m_q <= m_nx;
			end
		end
	end

	// s1: sample read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (n_q == '0);
			lastn_s1 <= (n_q == LAST_IDX);
			m_s1     <= m_q;
			k_s1     <= k_q;
		end
	end

	// s2: the two products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s2   <= first_s1;
			lastn_s2   <= lastn_s1;
			k_s2       <= k_s1;
			prod_re_s2 <= $signed(rd_data) * cos_q16(m_s1);
			prod_im_s2 <= $signed(rd_data) * sin_q16(m_s1);
		end
	end

	// s3: accumulate, imaginary part takes minus sine
	assign prod_re_ext = ACC_W'(prod_re_s2);
	assign prod_im_ext = ACC_W'(prod_im_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else if (adv) begin
			done_s3 <= v_s2 && lastn_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			k_s3 <= k_s2;
			if (first_s2) begin
				acc_re_s3 <= prod_re_ext;
				acc_im_s3 <= -prod_im_ext;
			end else begin
				acc_re_s3 <= acc_re_s3 + prod_re_ext;
				acc_im_s3 <= acc_im_s3 - prod_im_ext;
			end
		end
	end

	// round half up, arithmetic shift by the fraction width
	assign rnd_re = acc_re_s3 + ROUND_BIAS;
	assign rnd_im = acc_im_s3 + ROUND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done_s3) begin
			bin_real  <= rnd_re[FRAC_W+BIN_W-1:FRAC_W];
			bin_imag  <= rnd_im[FRAC_W+BIN_W-1:FRAC_W];
			bin_index <= k_s3;
			last_bin  <= (k_s3 == LAST_IDX);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dft_15_point_top.sv =====
//------------------------------------------------------------------------------
// dft_15_point_top
// 15-point forward DFT of a real signal in fixed point, bins in natural order.
//------------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_ready | sample (s16, time order)
//  output   | out_valid/out_ready | bin_real, bin_imag (s20), bin_index, last_bin
//
//  each bin takes one pass over the 15 samples on one shared complex
//  multiply-accumulate; the next frame can fill the other bank meanwhile
//  with the engine idle, the first bin follows the transaction that completes a
//  frame after the reads for bin 0 and the product, accumulate and output stages
//  reset clears counters, queue and valid flags; the sample store is not cleared
//  an output stall freezes the MAC pipeline; input stalls only while two full
//  frames are held in the two-bank sample store
//
`default_nettype none

module dft_15_point_top
	import dft15_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] sample,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [BIN_W-1:0]         bin_real,
	output logic [BIN_W-1:0]         bin_imag,
	output logic [IDX_W-1:0]         bin_index,
	output logic                     last_bin
);

	frame_info_t          frame_info;
	logic                 release_frame;
	logic                 wr_en, rd_en;
	logic [RAM_AW-1:0]    wr_addr, rd_addr;
	logic [SAMPLE_W-1:0]  wr_data, rd_data;

	// intake and frame queue
	dft15_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.release_frame (release_frame),
		.frame_info    (frame_info),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	// two banks of 15 samples, bank bit on top of the sample index
	dft15_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// bin engine with output register
	dft15_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_info    (frame_info),
		.release_frame (release_frame),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bin_real      (bin_real),
		.bin_imag      (bin_imag),
		.bin_index     (bin_index),
		.last_bin      (last_bin)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/dft15_checker.sv =====
//------------------------------------------------------------------------------
// dft15_checker
// Port-level checks on the result stream of the 15-point DFT.
//------------------------------------------------------------------------------
`default_nettype none

module dft15_checker
	import dft15_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [SAMPLE_W-1:0] sample,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [BIN_W-1:0]    bin_real,
	input wire logic [BIN_W-1:0]    bin_imag,
	input wire logic [IDX_W-1:0]    bin_index,
	input wire logic                last_bin
);

	// a stalled input transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
	else $error("sample changed while stalled");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_real) && $stable(bin_imag)
			&& $stable(bin_index))
	else $error("result changed while stalled");

	// end-of-frame flag marks exactly the top bin
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_bin == (bin_index == LAST_IDX)))
	else $error("last_bin disagrees with bin_index");

	// bin number stays within the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bin_index <= LAST_IDX))
	else $error("bin_index out of range");

	// a result that directly follows a taken result is the next bin
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_bin ##1 out_valid |->
			bin_index == $past(bin_index) + 1'b1 || $past(out_valid && out_ready, 1) == 1'b0)
	else $error("bin order broken");

endmodule

bind dft_15_point_top dft15_checker u_dft15_checker (.*);

`default_nettype wire

// ===== test/dft_15_point_checker.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dft_15_point_checker
// Watches both channels of the 15-point DFT, predicts the spectrum of every
// completed frame of samples and compares each bin transaction, field by field,
// with the oldest predicted bin.
//------------------------------------------------------------------------------

module dft_15_point_checker
	import dft15_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire logic [BIN_W-1:0]    bin_real,
	input  wire logic [BIN_W-1:0]    bin_imag,
	input  wire logic [IDX_W-1:0]    bin_index,
	input  wire logic                last_bin,
	output int                       fail_count,
	output int                       bins_pending
);

	// cos and sin of 2*pi*m/15, rounded to Q1.16
	localparam int COS_Q16 [FRAME_LEN] = '{
		65536, 59870, 43852, 20252, -6850, -32768, -53020, -64104,
		-64104, -53020, -32768, -6850, 20252, 43852, 59870
	};
	localparam int SIN_Q16 [FRAME_LEN] = '{
		0, 26656, 48703, 62328, 65177, 56756, 38521, 13626,
		-13626, -38521, -56756, -65177, -62328, -48703, -26656
	};

	typedef struct packed {
		logic [BIN_W-1:0] re;
		logic [BIN_W-1:0] im;
		logic [IDX_W-1:0] idx;
		logic             last_flag;
	} spectrum_bin_t;

	shortint       frame_samples [FRAME_LEN];
	int            samples_held;
	spectrum_bin_t due_bins [$];

	// exact sums, then round half up and keep 20 bits
	function automatic spectrum_bin_t compute_bin(input int k);
		longint        acc_re;
		longint        acc_im;
		int            m;
		spectrum_bin_t b;
		acc_re = 0;
		acc_im = 0;
		for (int n = 0; n < FRAME_LEN; n++) begin
			m = (n * k) % FRAME_LEN;
			acc_re += longint'(frame_samples[n]) * longint'(COS_Q16[m]);
			acc_im -= longint'(frame_samples[n]) * longint'(SIN_Q16[m]);
		end
		b.re        = BIN_W'((acc_re + 64'sd32768) >>> FRAC_W);
		b.im        = BIN_W'((acc_im + 64'sd32768) >>> FRAC_W);
		b.idx       = IDX_W'(k);
		b.last_flag = (k == FRAME_LEN - 1);
		return b;
	endfunction

	task automatic check_field(input string what, input logic [IDX_W-1:0] k,
			input logic [BIN_W-1:0] want, input logic [BIN_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: bin %0d %s mismatch, expected 0x%05h, actual 0x%05h",
				$time, k, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		spectrum_bin_t want;
		if (!arst_n) begin
			fail_count   = 0;
			samples_held = 0;
			bins_pending = 0;
			due_bins.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (due_bins.size() == 0) begin
					fail_count++;
					$display("%0t: bin transaction with none expected, index %0d",
						$time, bin_index);
				end else begin
					want = due_bins.pop_front();
					check_field("bin_real", want.idx, want.re, bin_real);
					check_field("bin_imag", want.idx, want.im, bin_imag);
					check_field("bin_index", want.idx, BIN_W'(want.idx), BIN_W'(bin_index));
					check_field("last_bin", want.idx, BIN_W'(want.last_flag),
						BIN_W'(last_bin));
				end
			end
			if (in_valid && in_ready) begin
				frame_samples[samples_held] = shortint'(sample);
				samples_held++;
				if (samples_held == FRAME_LEN) begin
					for (int k = 0; k < FRAME_LEN; k++)
						due_bins.push_back(compute_bin(k));
					samples_held = 0;
				end
			end
			bins_pending = due_bins.size();
		end
	end

endmodule

// ===== test/dft_15_point_top_tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dft_15_point_top_tb
// Feeds frames of signed samples into the 15-point DFT with random gaps and
// output stalls, and leaves prediction and comparison of every bin to the
// checker beside the block.
//------------------------------------------------------------------------------

module dft_15_point_top_tb;
	import dft15_pkg::*;

	// generous bound: ~27 frames, long sender gaps, long
	// receiver stalls and one long hold-off, many times over
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_FRAMES = 25;
	localparam int TAIL_SAMPLES  = 7;
	localparam int HOLD_CYCLES   = 3000;
	localparam int HOLD_FRAME    = 8;
	localparam int PAUSE_FRAME   = 16;
	localparam int DRAIN_CYCLES  = 40;

	// how the samples of one random frame are drawn
	typedef enum int {
		FULL_RANGE,
		LOW_LEVEL,
		RAIL_VALUES,
		CONSTANT_LEVEL
	} sample_kind_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic [BIN_W-1:0]    bin_real;
	logic [BIN_W-1:0]    bin_imag;
	logic [IDX_W-1:0]    bin_index;
	logic                last_bin;

	int          fail_count;
	int          bins_pending;
	bit          hold_req;
	bit          hold_done;
	int unsigned cycle_count = 0;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	dft_15_point_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_real  (bin_real),
		.bin_imag  (bin_imag),
		.bin_index (bin_index),
		.last_bin  (last_bin)
	);

	dft_15_point_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_real     (bin_real),
		.bin_imag     (bin_imag),
		.bin_index    (bin_index),
		.last_bin     (last_bin),
		.fail_count   (fail_count),
		.bins_pending (bins_pending)
	);

	// idle length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_kind_t kind,
			input logic [SAMPLE_W-1:0] level);
		case (kind)
			FULL_RANGE: return SAMPLE_W'($urandom);
			LOW_LEVEL:  return SAMPLE_W'($urandom_range(0, 127)) - SAMPLE_W'(64);
			RAIL_VALUES: begin
				case ($urandom_range(0, 3))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
			default:    return level;
		endcase
	endfunction

	// hold valid and payload until the transaction goes through
	task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
		in_valid <= 1'b1;
		sample   <= value;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid for a while after a transaction, or keep streaming
	task automatic idle_after(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender waits until every predicted bin has been taken
	task automatic drain_bins();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bins_pending != 0)
			@(posedge clk);
	endtask

	// cycle watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dft_15_point_top verification failed");
			$finish;
		end
	end

	// receiver: random stalls, long ready stretches, and one long hold-off
	// that backs the block up until it refuses input
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(50, 150)) @(posedge clk);
				else
					repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// sender and verdict
	initial begin
		sample_kind_t        kind;
		logic [SAMPLE_W-1:0] level;
		bit                  steady;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		hold_req    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: alternating rails (energy at the top bins), then full
		// scale negative dc (largest bin 0 magnitude)
		for (int i = 0; i < FRAME_LEN; i++) begin
			offer_sample((i % 2) ? 16'h8000 : 16'h7FFF);
			idle_after(pick_gap());
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			offer_sample(16'h8000);
			idle_after(pick_gap());
		end
		drain_bins();

		// random frames; each frame keeps one flavour of samples
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			if (f == HOLD_FRAME)
				hold_req = 1'b1;
			kind   = sample_kind_t'($urandom_range(0, 3));
			level  = SAMPLE_W'($urandom);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < FRAME_LEN; i++) begin
				offer_sample(pick_sample(kind, level));
				// stream back to back while the receiver is held off
				idle_after((steady || (hold_req && !hold_done)) ? 0 : pick_gap());
			end
			if (f == PAUSE_FRAME)
				drain_bins();
		end

		// partial frame at the end: no bins may follow
		for (int i = 0; i < TAIL_SAMPLES; i++) begin
			offer_sample(SAMPLE_W'($urandom));
			idle_after(pick_gap());
		end
		drain_bins();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && bins_pending == 0)
			$display("dft_15_point_top verification clean");
		else
			$display("dft_15_point_top verification failed");
		$finish;
	end

endmodule

// ===== dft_15_point_top.f =====
hw/rtl/dft15_pkg.sv
hw/rtl/dft15_ram.sv
hw/rtl/dft15_front.sv
hw/rtl/dft15_back.sv
hw/rtl/dft_15_point_top.sv
hw/rtl/dft15_checker.sv
test/dft_15_point_checker.sv
test/dft_15_point_top_tb.sv
